FILE: src/jse_pkg.sv
// ---------------------------------------------------------------------------
// jse_pkg: shared types and character codes
// Character constants and the result type of the escape character unit.
// ---------------------------------------------------------------------------
package jse_pkg;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_U         = 8'h75;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_CR        = 8'h0D;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} esc_t;

endpackage

FILE: src/json_string_escape_utf8.sv
// ---------------------------------------------------------------------------
// json_string_escape_utf8: JSON string literal encoder with UTF-8 checking
// Turns a stream of string bytes into the text of a JSON string literal.
// ---------------------------------------------------------------------------
// Each input transfer is taken when the block is ready; the block then
// sends its characters one per cycle, while the output side accepts
// them, through a single output register, all produced by one shared
// escape character unit. An item causes up to 30 characters, and the
// block takes no new item until all of them are registered. An item that
// only extends a held UTF-8 sequence causes no characters and the block
// is ready again in the next cycle. The input tlast closes the string:
// held bytes are flushed and the closing quote is sent. Valid multi-byte
// sequences pass unchanged; bytes of broken sequences come out as \u00hh.
module json_string_escape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // in_byte[7:0]
	input  logic       s_axis_tlast,   // end_of_string
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte[7:0]
	output logic       m_axis_tlast    // out_last
);
	import jse_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_OPEN, ST_FLUSH, ST_FRESH, ST_CLOSE} state_t;

	state_t     state_q;
	logic       open_q;
	logic [7:0] held_q [4];
	logic [2:0] cnt_q;
	logic [2:0] exp_q;
	logic [7:0] fb_q [4];
	logic [2:0] fl_cnt_q;
	logic       raw_q;
	logic       pl_flush_q;
	logic       pl_esc_q;
	logic       pl_close_q;
	logic [7:0] b_q;
	logic [2:0] k_q;
	logic [1:0] i_q;

	logic       acc, eos, cont, in_rng, fresh_hold;
	logic [7:0] b;
	logic [2:0] len, cnt_eff;
	logic       p_flush, p_raw, p_fresh, p_close, p_append;
	state_t     first_st, n_flush, n_open, nxt;
	logic       ld, last_byte, phase_done;
	logic [7:0] u_byte;
	logic       u_raw;
	esc_t       u_res;

	function automatic logic [2:0] lead_len(input logic [7:0] v);
		if (!v[7])               return 3'd1;
		if (v[7:5] == 3'b110)    return 3'd2;
		if (v[7:4] == 4'b1110)   return 3'd3;
		if (v[7:3] == 5'b11110)  return 3'd4;
		return 3'd0;
	endfunction

	always_comb begin
		logic [20:0] cp;
		cp = 21'd0;
		in_rng = 1'b0;
		case (exp_q)
			3'd2: begin
				cp = {10'd0, held_q[0][4:0], held_q[1][5:0]};
				in_rng = (cp >= 21'h80);
			end
			3'd3: begin
				cp = {5'd0, held_q[0][3:0], held_q[1][5:0], held_q[2][5:0]};
				in_rng = (cp >= 21'h800) && !((cp >= 21'hD800) && (cp <= 21'hDFFF));
			end
			3'd4: begin
				cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], held_q[3][5:0]};
				in_rng = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
			end
			default: in_rng = 1'b0;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc  = s_axis_tvalid && s_axis_tready;
	assign b    = s_axis_tdata;
	assign eos  = s_axis_tlast;
	assign cont = (b[7:6] == 2'b10);
	assign len  = lead_len(b);
	assign cnt_eff = open_q ? cnt_q : 3'd0;
	assign fresh_hold = b[7] && (len >= 3'd2);

	always_comb begin
		p_flush  = 1'b0;
		p_raw    = 1'b0;
		p_fresh  = 1'b0;
		p_close  = 1'b0;
		p_append = 1'b0;
		if (eos) begin
			p_close = 1'b1;
			p_flush = (cnt_eff != 3'd0);
			p_raw   = (cnt_eff == exp_q) && in_rng;
		end else if (cnt_eff == 3'd0) begin
			p_fresh = 1'b1;
		end else if ((cnt_eff < exp_q) && (cnt_eff < 3'd4)) begin
			if (cont) begin
				p_append = 1'b1;
			end else begin
				p_flush = 1'b1;
				p_fresh = 1'b1;
			end
		end else begin
			p_flush = 1'b1;
			p_raw   = !cont && (cnt_eff == exp_q) && in_rng;
			p_fresh = 1'b1;
		end
	end

	always_comb begin
		if (!open_q)                   first_st = ST_OPEN;
		else if (p_flush)              first_st = ST_FLUSH;
		else if (p_fresh && !fresh_hold) first_st = ST_FRESH;
		else if (p_close)              first_st = ST_CLOSE;
		else                           first_st = ST_IDLE;
	end

	always_comb begin
		u_byte = CH_QUOTE;
		u_raw  = 1'b1;
		unique case (state_q)
			ST_FLUSH: begin
				u_byte = fb_q[i_q];
				u_raw  = raw_q;
			end
			ST_FRESH: begin
				u_byte = b_q;
				u_raw  = 1'b0;
			end
			default: begin
				u_byte = CH_QUOTE;
				u_raw  = 1'b1;
			end
		endcase
	end

	jse_esc u_esc (
		.byte_in (u_byte),
		.raw     (u_raw),
		.idx     (k_q),
		.res     (u_res)
	);

	assign ld        = !m_axis_tvalid || m_axis_tready;
	assign last_byte = ({1'b0, i_q} == (fl_cnt_q - 3'd1));
	assign n_flush   = pl_esc_q ? ST_FRESH : (pl_close_q ? ST_CLOSE : ST_IDLE);
	assign n_open    = pl_flush_q ? ST_FLUSH : n_flush;

	always_comb begin
		unique case (state_q)
			ST_OPEN:  nxt = n_open;
			ST_FLUSH: nxt = n_flush;
			default:  nxt = ST_IDLE;
		endcase
		phase_done = u_res.last && ((state_q != ST_FLUSH) || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			open_q        <= 1'b0;
			cnt_q         <= 3'd0;
			exp_q         <= 3'd0;
			fl_cnt_q      <= 3'd0;
			raw_q         <= 1'b0;
			pl_flush_q    <= 1'b0;
			pl_esc_q      <= 1'b0;
			pl_close_q    <= 1'b0;
			b_q           <= 8'd0;
			k_q           <= 3'd0;
			i_q           <= 2'd0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= 8'd0;
			m_axis_tlast  <= 1'b0;
			for (int j = 0; j < 4; j++) begin
				held_q[j] <= 8'd0;
				fb_q[j]   <= 8'd0;
			end
		end else begin
			if (acc) begin
				open_q     <= !eos;
				fb_q       <= held_q;
				fl_cnt_q   <= cnt_eff;
				raw_q      <= p_raw;
				pl_flush_q <= p_flush;
				pl_esc_q   <= p_fresh && !fresh_hold;
				pl_close_q <= p_close;
				b_q        <= b;
				k_q        <= 3'd0;
				i_q        <= 2'd0;
				state_q    <= first_st;
				if (p_append) begin
					held_q[cnt_q[1:0]] <= b;
					cnt_q <= cnt_q + 3'd1;
				end else if (p_fresh && fresh_hold) begin
					held_q[0] <= b;
					cnt_q     <= 3'd1;
					exp_q     <= len;
				end else begin
					cnt_q <= 3'd0;
					exp_q <= 3'd0;
				end
			end else if ((state_q != ST_IDLE) && ld) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tdata  <= u_res.ch;
				m_axis_tlast  <= phase_done && (nxt == ST_IDLE);
				if (u_res.last) begin
					k_q <= 3'd0;
					if ((state_q == ST_FLUSH) && !last_byte) begin
						i_q <= i_q + 2'd1;
					end else begin
						i_q     <= 2'd0;
						state_q <= nxt;
					end
				end else begin
					k_q <= k_q + 3'd1;
				end
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			if (acc && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= exp_q) && (cnt_q <= 3'd4))
		else $error("held count exceeds expected sequence length");

	a_held_open: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 3'd0) |-> open_q)
		else $error("bytes held while the string is closed");

	a_flush_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> ((fl_cnt_q != 3'd0) && ({1'b0, i_q} < fl_cnt_q)))
		else $error("flush index outside the held bytes");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && (state_q != ST_IDLE) && !acc && phase_done && (nxt == ST_IDLE))
		|=> (state_q == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
		else $error("last character sent without returning to idle");

endmodule

FILE: src/jse_esc.sv
// ---------------------------------------------------------------------------
// jse_esc: escape character unit
// Gives character number idx of the JSON form of one byte, and marks the
// last character of that form. In raw mode the byte is its own form.
// ---------------------------------------------------------------------------
module jse_esc (
	input  logic [7:0]    byte_in,
	input  logic          raw,
	input  logic [2:0]    idx,
	output jse_pkg::esc_t res
);
	import jse_pkg::*;

	logic [7:0] two;
	logic       is_two;
	logic       is_six;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
	endfunction

	always_comb begin
		two = 8'h00;
		case (byte_in)
			CH_QUOTE:     two = CH_QUOTE;
			CH_BACKSLASH: two = CH_BACKSLASH;
			CH_BS:        two = "b";
			CH_FF:        two = "f";
			CH_LF:        two = "n";
			CH_CR:        two = "r";
			CH_TAB:       two = "t";
			default:      two = 8'h00;
		endcase
		is_two = !raw && (two != 8'h00);
		is_six = !raw && !is_two && ((byte_in < 8'd32) || byte_in[7]);

		res.ch   = byte_in;
		res.last = (idx == 3'd0);
		if (is_two) begin
			res.ch   = (idx == 3'd0) ? CH_BACKSLASH : two;
			res.last = (idx == 3'd1);
		end else if (is_six) begin
			unique case (idx) inside
				3'd0:         res.ch = CH_BACKSLASH;
				3'd1:         res.ch = CH_U;
				3'd2, 3'd3:   res.ch = CH_ZERO;
				3'd4:         res.ch = hex_char(byte_in[7:4]);
				default:      res.ch = hex_char(byte_in[3:0]);
			endcase
			res.last = (idx == 3'd5);
		end
	end

endmodule
